// ===== hdl/mcfp_pkg.sv =====
// Shared types and constants for the motor command frame packer.
// No dependencies; used by every module of the block.
package mcfp_pkg;

  localparam int DEF_INPUT_FRAC_BITS = 16;

  localparam int VAL_W   = 32;
  localparam int CODE_W  = 16;
  localparam int ID_W    = 8;
  localparam int FRAME_W = 25;
  localparam int TW      = 26;   // holds 65535 * largest span in half units

  localparam int REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_FIRST_ID  = 1'd0;
  localparam logic [REG_IDX_W-1:0] REG_SECOND_ID = 1'd1;

  localparam logic [ID_W-1:0] FIRST_ID_RST  = 8'd127;
  localparam logic [ID_W-1:0] SECOND_ID_RST = 8'd126;

  localparam logic MODE_EXT = 1'b1;

  // range ends in half units
  typedef struct packed {
    int lo_half;
    int hi_half;
  } span_t;

  localparam span_t TORQUE_SPAN    = '{lo_half: -24, hi_half: 24};
  localparam span_t POSITION_SPAN  = '{lo_half: -25, hi_half: 25};
  localparam span_t VELOCITY_SPAN  = '{lo_half: -60, hi_half: 60};
  localparam span_t STIFFNESS_SPAN = '{lo_half: 0,   hi_half: 1000};
  localparam span_t DAMPING_SPAN   = '{lo_half: 0,   hi_half: 10};

  typedef struct packed {
    logic en0;
    logic en1;
    logic en2;
  } pipe_en_t;

endpackage

// ===== hdl/motor_command_frame_packer.sv =====
// Top level of the motor command frame packer.
// Depends on mcfp_pkg, mcfp_flow and mcfp_scale.

// Takes one item per clock while in_stall is low. An accepted item passes
// through the input, correction and output registers in turn, and its frame
// leaves the output when out_stall is low. A full pipeline holds three items.
// Each of the five scalers clamps its value, multiplies by 65535 with a shift
// and subtract, and divides by its span with a registered reciprocal multiply
// followed by a one-step correction. The input, correction and output
// registers make the three stages. The motor id is taken from first_id or
// second_id by motor_select; write these only while no item is in flight.
module motor_command_frame_packer #(
  parameter int INPUT_FRAC_BITS = mcfp_pkg::DEF_INPUT_FRAC_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [mcfp_pkg::REG_IDX_W-1:0]       cfg_index,
  input  logic [mcfp_pkg::ID_W-1:0]            cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 motor_select,
  input  logic signed [mcfp_pkg::VAL_W-1:0]    torque_in,
  input  logic signed [mcfp_pkg::VAL_W-1:0]    position_in,
  input  logic signed [mcfp_pkg::VAL_W-1:0]    velocity_in,
  input  logic signed [mcfp_pkg::VAL_W-1:0]    stiffness_in,
  input  logic signed [mcfp_pkg::VAL_W-1:0]    damping_in,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [mcfp_pkg::FRAME_W-1:0]         frame_id,
  output logic [mcfp_pkg::CODE_W-1:0]          position_code,
  output logic [mcfp_pkg::CODE_W-1:0]          velocity_code,
  output logic [mcfp_pkg::CODE_W-1:0]          stiffness_code,
  output logic [mcfp_pkg::CODE_W-1:0]          damping_code,
  output logic                                 motor_echo
);
  import mcfp_pkg::*;

  pipe_en_t   en;
  logic [2:0] stage_valid;

  logic [ID_W-1:0] first_id;
  logic [ID_W-1:0] second_id;

  logic                    sel_in;
  logic                    sel_mid;
  logic signed [VAL_W-1:0] torque_r;
  logic signed [VAL_W-1:0] position_r;
  logic signed [VAL_W-1:0] velocity_r;
  logic signed [VAL_W-1:0] stiffness_r;
  logic signed [VAL_W-1:0] damping_r;

  logic [CODE_W-1:0] torque_c;
  logic [CODE_W-1:0] position_c;
  logic [CODE_W-1:0] velocity_c;
  logic [CODE_W-1:0] stiffness_c;
  logic [CODE_W-1:0] damping_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_id  <= FIRST_ID_RST;
      second_id <= SECOND_ID_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FIRST_ID:  first_id  <= cfg_data;
        REG_SECOND_ID: second_id <= cfg_data;
        default: ;
      endcase
    end
  end

  mcfp_flow u_flow (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_stall   (out_stall),
    .en          (en),
    .stage_valid (stage_valid)
  );

  always_ff @(posedge clk) begin
    if (en.en0) begin
      sel_in      <= motor_select;
      torque_r    <= torque_in;
      position_r  <= position_in;
      velocity_r  <= velocity_in;
      stiffness_r <= stiffness_in;
      damping_r   <= damping_in;
    end
    if (en.en1) begin
      sel_mid <= sel_in;
    end
  end

  mcfp_scale #(.FRAC_BITS(INPUT_FRAC_BITS), .SPAN(TORQUE_SPAN)) u_torque (
    .clk(clk), .en(en), .x(torque_r), .code(torque_c)
  );
  mcfp_scale #(.FRAC_BITS(INPUT_FRAC_BITS), .SPAN(POSITION_SPAN)) u_position (
    .clk(clk), .en(en), .x(position_r), .code(position_c)
  );
  mcfp_scale #(.FRAC_BITS(INPUT_FRAC_BITS), .SPAN(VELOCITY_SPAN)) u_velocity (
    .clk(clk), .en(en), .x(velocity_r), .code(velocity_c)
  );
  mcfp_scale #(.FRAC_BITS(INPUT_FRAC_BITS), .SPAN(STIFFNESS_SPAN)) u_stiffness (
    .clk(clk), .en(en), .x(stiffness_r), .code(stiffness_c)
  );
  mcfp_scale #(.FRAC_BITS(INPUT_FRAC_BITS), .SPAN(DAMPING_SPAN)) u_damping (
    .clk(clk), .en(en), .x(damping_r), .code(damping_c)
  );

  always_ff @(posedge clk) begin
    if (en.en2) begin
      frame_id       <= {MODE_EXT, torque_c, (sel_mid ? second_id : first_id)};
      position_code  <= position_c;
      velocity_code  <= velocity_c;
      stiffness_code <= stiffness_c;
      damping_code   <= damping_c;
      motor_echo     <= sel_mid;
    end
  end

  assign out_valid = stage_valid[2];

  a_mode_bit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> frame_id[FRAME_W-1] == MODE_EXT)
    else $error("frame without extended mode bit");

  a_flow_through: assert property (@(posedge clk) disable iff (rst)
    !out_stall |-> !in_stall)
    else $error("input stalled while output drains");

  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> stage_valid[0])
    else $error("accepted item lost at input stage");

endmodule

// ===== hdl/mcfp_flow.sv =====
// Valid/stall flow control of the three-stage item pipeline.
// Depends on mcfp_pkg.
module mcfp_flow (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              out_stall,
  output mcfp_pkg::pipe_en_t en,
  output logic [2:0]        stage_valid
);
  import mcfp_pkg::*;

  logic [2:0] vld;

  always_comb begin
    en.en2   = !vld[2] || !out_stall;
    en.en1   = !vld[1] || en.en2;
    en.en0   = !vld[0] || en.en1;
    in_stall = !en.en0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en.en0) vld[0] <= in_valid;
      if (en.en1) vld[1] <= vld[0];
      if (en.en2) vld[2] <= vld[1];
    end
  end

  assign stage_valid = vld;

endmodule

// ===== hdl/mcfp_scale.sv =====
// Clamp and linear scale of one Q-format value onto a 16-bit code.
// Depends on mcfp_pkg; division by the span uses a reciprocal multiply.
module mcfp_scale #(
  parameter int              FRAC_BITS = mcfp_pkg::DEF_INPUT_FRAC_BITS,
  parameter mcfp_pkg::span_t SPAN      = mcfp_pkg::TORQUE_SPAN
) (
  input  logic                              clk,
  input  mcfp_pkg::pipe_en_t                en,
  input  logic signed [mcfp_pkg::VAL_W-1:0] x,
  output logic [mcfp_pkg::CODE_W-1:0]       code
);
  import mcfp_pkg::*;

  localparam int XW = (FRAC_BITS + 11 > VAL_W + 1) ? FRAC_BITS + 11 : VAL_W + 1;
  localparam int DW = XW - 1;
  localparam int PW = DW + CODE_W;
  localparam longint UNIT_HALF = longint'(1) << (FRAC_BITS - 1);
  localparam logic signed [XW-1:0] LO = XW'(longint'(SPAN.lo_half) * UNIT_HALF);
  localparam logic signed [XW-1:0] HI = XW'(longint'(SPAN.hi_half) * UNIT_HALF);
  localparam int S = SPAN.hi_half - SPAN.lo_half;
  localparam logic [TW-1:0] SV = TW'(S);
  localparam logic [TW-1:0] RECIP = TW'((longint'(1) << TW) / S);

  logic signed [XW-1:0] xe;
  logic signed [XW-1:0] xc;
  logic [XW-1:0]        diff;
  logic [DW-1:0]        d;
  logic [PW-1:0]        prod;
  logic [TW-1:0]        t;
  logic [2*TW-1:0]      qp;
  logic [TW-1:0]        t_mid;
  logic [CODE_W-1:0]    q_mid;
  logic [TW-1:0]        qs;
  logic [TW-1:0]        rem;

  always_comb begin
    xe = {{(XW-VAL_W){x[VAL_W-1]}}, x};
    if (xe > HI) begin
      xc = HI;
    end else if (xe < LO) begin
      xc = LO;
    end else begin
      xc = xe;
    end
    diff = xc - LO;
    d    = diff[DW-1:0];
    prod = {d, {CODE_W{1'b0}}} - {{CODE_W{1'b0}}, d};   // d * 65535
    t    = prod[FRAC_BITS-1 +: TW];
    qp   = (2*TW)'(t) * (2*TW)'(RECIP);
  end

  always_ff @(posedge clk) begin
    if (en.en1) begin
      t_mid <= t;
      q_mid <= qp[TW +: CODE_W];
    end
  end

  // estimate is exact or one low
  always_comb begin
    qs   = TW'(q_mid) * SV;
    rem  = t_mid - qs;
    code = q_mid + CODE_W'(rem >= SV);
  end

endmodule

// ===== dv/tb_motor_command_frame_packer.sv =====
// Self-checking testbench for motor_command_frame_packer: directed and random commands,
// both motor ids reprogrammed between phases, random idling on both handshakes.
// Depends on mcfp_pkg and the RTL of the block.
module tb_motor_command_frame_packer;
  import mcfp_pkg::*;

  localparam int FRAC       = 16;
  localparam int CODE_MAX   = 65535;
  localparam int CYCLE_MAX  = 400000;
  localparam int SETTLE     = 8;
  localparam int PHASES     = 6;
  localparam int PHASE_CMDS = 225;

  // range ends in half units
  localparam int TRQ_LO_H = -24;
  localparam int TRQ_HI_H = 24;
  localparam int POS_LO_H = -25;
  localparam int POS_HI_H = 25;
  localparam int VEL_LO_H = -60;
  localparam int VEL_HI_H = 60;
  localparam int KP_LO_H  = 0;
  localparam int KP_HI_H  = 1000;
  localparam int KD_LO_H  = 0;
  localparam int KD_HI_H  = 10;

  typedef struct packed {
    logic                    sel;
    logic signed [VAL_W-1:0] torque;
    logic signed [VAL_W-1:0] position;
    logic signed [VAL_W-1:0] velocity;
    logic signed [VAL_W-1:0] stiffness;
    logic signed [VAL_W-1:0] damping;
  } command_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame_id;
    logic [CODE_W-1:0]  position_code;
    logic [CODE_W-1:0]  velocity_code;
    logic [CODE_W-1:0]  stiffness_code;
    logic [CODE_W-1:0]  damping_code;
    logic               motor_echo;
  } frame_t;

  class frame_scoreboard;
    logic [ID_W-1:0] first_id;
    logic [ID_W-1:0] second_id;
    frame_t          pending_frames[$];
    int              errors;

    function new();
      first_id  = FIRST_ID_RST;
      second_id = SECOND_ID_RST;
      errors    = 0;
    endfunction

    static function longint fixed_bound(int half);
      return longint'(half) * (longint'(1) << (FRAC - 1));
    endfunction

    function void set_id(logic [REG_IDX_W-1:0] idx, logic [ID_W-1:0] id);
      if (idx == REG_FIRST_ID) first_id = id;
      else if (idx == REG_SECOND_ID) second_id = id;
    endfunction

    function logic [CODE_W-1:0] scaled_code(logic signed [VAL_W-1:0] raw, int lo_h, int hi_h);
      longint x;
      longint lo;
      longint hi;
      x  = longint'(raw);
      lo = fixed_bound(lo_h);
      hi = fixed_bound(hi_h);
      if (x > hi) x = hi;
      else if (x < lo) x = lo;
      return CODE_W'(((x - lo) * CODE_MAX) / (hi - lo));
    endfunction

    function void note_command(command_t c);
      frame_t f;
      f.frame_id = {MODE_EXT, scaled_code(c.torque, TRQ_LO_H, TRQ_HI_H),
                    c.sel ? second_id : first_id};
      f.position_code  = scaled_code(c.position, POS_LO_H, POS_HI_H);
      f.velocity_code  = scaled_code(c.velocity, VEL_LO_H, VEL_HI_H);
      f.stiffness_code = scaled_code(c.stiffness, KP_LO_H, KP_HI_H);
      f.damping_code   = scaled_code(c.damping, KD_LO_H, KD_HI_H);
      f.motor_echo     = c.sel;
      pending_frames.push_back(f);
    endfunction

    function void compare(string name, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
        $error("%s mismatch: expected %0h actual %0h", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_frame(frame_t got);
      frame_t exp_f;
      if (pending_frames.size() == 0) begin
        $error("unexpected frame: frame_id %0h", got.frame_id);
        errors++;
        return;
      end
      exp_f = pending_frames.pop_front();
      compare("frame_id", exp_f.frame_id, got.frame_id);
      compare("position_code", exp_f.position_code, got.position_code);
      compare("velocity_code", exp_f.velocity_code, got.velocity_code);
      compare("stiffness_code", exp_f.stiffness_code, got.stiffness_code);
      compare("damping_code", exp_f.damping_code, got.damping_code);
      compare("motor_echo", exp_f.motor_echo, got.motor_echo);
    endfunction

    function int pending();
      return pending_frames.size();
    endfunction
  endclass

  logic                    clk;
  logic                    rst;
  logic                    cfg_write;
  logic [REG_IDX_W-1:0]    cfg_index;
  logic [ID_W-1:0]         cfg_data;
  logic                    in_valid;
  logic                    in_stall;
  logic                    motor_select;
  logic signed [VAL_W-1:0] torque_in;
  logic signed [VAL_W-1:0] position_in;
  logic signed [VAL_W-1:0] velocity_in;
  logic signed [VAL_W-1:0] stiffness_in;
  logic signed [VAL_W-1:0] damping_in;
  logic                    out_valid;
  logic                    out_stall;
  logic [FRAME_W-1:0]      frame_id;
  logic [CODE_W-1:0]       position_code;
  logic [CODE_W-1:0]       velocity_code;
  logic [CODE_W-1:0]       stiffness_code;
  logic [CODE_W-1:0]       damping_code;
  logic                    motor_echo;

  frame_scoreboard sb;
  int              idle_pct;
  int              cycles;

  motor_command_frame_packer #(.INPUT_FRAC_BITS(FRAC)) dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .motor_select   (motor_select),
    .torque_in      (torque_in),
    .position_in    (position_in),
    .velocity_in    (velocity_in),
    .stiffness_in   (stiffness_in),
    .damping_in     (damping_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .frame_id       (frame_id),
    .position_code  (position_code),
    .velocity_code  (velocity_code),
    .stiffness_code (stiffness_code),
    .damping_code   (damping_code),
    .motor_echo     (motor_echo)
  );

  initial begin
    clk          = 1'b0;
    rst          = 1'b1;
    cfg_write    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    in_valid     = 1'b0;
    motor_select = 1'b0;
    torque_in    = '0;
    position_in  = '0;
    velocity_in  = '0;
    stiffness_in = '0;
    damping_in   = '0;
    out_stall    = 1'b0;
    idle_pct     = 21;
    cycles       = 0;
    sb           = new();
  end

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_MAX) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_stall <= !rst && ($urandom_range(99) < idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_frame({frame_id, position_code, velocity_code, stiffness_code,
                      damping_code, motor_echo});
  end

  // called at a falling edge, returns at a falling edge
  task automatic write_id(logic [REG_IDX_W-1:0] idx, logic [ID_W-1:0] id);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= id;
    sb.set_id(idx, id);
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_command(command_t c);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    motor_select <= c.sel;
    torque_in    <= c.torque;
    position_in  <= c.position;
    velocity_in  <= c.velocity;
    stiffness_in <= c.stiffness;
    damping_in   <= c.damping;
    do @(posedge clk); while (in_stall);
    sb.note_command(c);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic signed [VAL_W-1:0] random_value(int lo_h, int hi_h);
    longint lo;
    longint hi;
    longint v;
    lo = frame_scoreboard::fixed_bound(lo_h);
    hi = frame_scoreboard::fixed_bound(hi_h);
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: v = lo + $urandom_range(int'(hi - lo));
      6: v = longint'($signed($urandom));
      7: v = ($urandom_range(1) ? hi : lo) + $urandom_range(4) - 2;
      8: v = $urandom_range(1) ? 64'sd2147483647 - $urandom_range(3)
                               : -64'sd2147483648 + $urandom_range(3);
      default: v = $urandom_range(1) ? hi + $urandom_range(1 << 20)
                                     : lo - $urandom_range(1 << 20);
    endcase
    return v[VAL_W-1:0];
  endfunction

  function automatic command_t random_command();
    command_t c;
    c.sel       = 1'($urandom_range(1));
    c.torque    = random_value(TRQ_LO_H, TRQ_HI_H);
    c.position  = random_value(POS_LO_H, POS_HI_H);
    c.velocity  = random_value(VEL_LO_H, VEL_HI_H);
    c.stiffness = random_value(KP_LO_H, KP_HI_H);
    c.damping   = random_value(KD_LO_H, KD_HI_H);
    return c;
  endfunction

  // every field at the same offset from its own range end
  function automatic command_t edge_command(logic sel, bit upper, int offset);
    command_t c;
    c.sel       = sel;
    c.torque    = VAL_W'(frame_scoreboard::fixed_bound(upper ? TRQ_HI_H : TRQ_LO_H) + offset);
    c.position  = VAL_W'(frame_scoreboard::fixed_bound(upper ? POS_HI_H : POS_LO_H) + offset);
    c.velocity  = VAL_W'(frame_scoreboard::fixed_bound(upper ? VEL_HI_H : VEL_LO_H) + offset);
    c.stiffness = VAL_W'(frame_scoreboard::fixed_bound(upper ? KP_HI_H : KP_LO_H) + offset);
    c.damping   = VAL_W'(frame_scoreboard::fixed_bound(upper ? KD_HI_H : KD_LO_H) + offset);
    return c;
  endfunction

  initial begin
    logic [ID_W-1:0] first_ids[PHASES];
    logic [ID_W-1:0] second_ids[PHASES];
    command_t        c;
    first_ids  = '{8'd0, 8'd255, 8'd255, 8'd0,
                   ID_W'($urandom_range(255)), ID_W'($urandom_range(255))};
    second_ids = '{8'd255, 8'd0, 8'd255, 8'd0,
                   ID_W'($urandom_range(255)), ID_W'($urandom_range(255))};
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed, reset ids
    send_command('0);
    send_command({1'b1, {5{32'h7fffffff}}});
    send_command({1'b0, {5{32'h80000000}}});
    send_command({1'b1, {5{32'hffffffff}}});
    send_command({1'b0, {5{32'h00000001}}});
    send_command(edge_command(1'b0, 1'b0, 0));
    send_command(edge_command(1'b1, 1'b1, 0));
    send_command(edge_command(1'b0, 1'b0, -1));
    send_command(edge_command(1'b1, 1'b1, 1));
    send_command(edge_command(1'b0, 1'b0, 1));
    send_command(edge_command(1'b1, 1'b1, -1));
    send_command({1'b0, 32'sd0, 32'sd0, 32'sd0, 32'sd16384000, 32'sd163840});
    send_command({1'b1, 32'sd393216, -32'sd409600, 32'sd983040, 32'sd8192000,
                  32'sd81920});
    repeat (10) send_command(random_command());

    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      write_id(REG_FIRST_ID, first_ids[p]);
      write_id(REG_SECOND_ID, second_ids[p]);
      idle_pct = (p == 2) ? 0 : 21;
      repeat (PHASE_CMDS) send_command(random_command());
    end

    wait_drained();
    if (sb.errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/mcfp_pkg.sv
hdl/mcfp_flow.sv
hdl/mcfp_scale.sv
hdl/motor_command_frame_packer.sv
dv/tb_motor_command_frame_packer.sv
